>>> hw/rtl/spqt_pkg.sv
`timescale 1ns / 1ps

package spqt_pkg;

    // Default configuration of the table
    localparam int NUM_SIGNALS_DEF = 32;
    localparam int QUEUE_LIMIT_DEF = 3;
    localparam int RING_DEPTH_DEF  = 4;
    localparam int KILL_SIGNAL_DEF = 9;

    localparam int PAYLOAD_W = 64;
    localparam int SIGNO_W   = 5;
    localparam int MASK_W    = 32;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_QSEND   = 2'd1,
        CMD_CLAIM   = 2'd2,
        CMD_RESTORE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // One command beat as held in the input register
    typedef struct packed {
        cmd_t                 command;
        logic [SIGNO_W-1:0]   signo;
        logic [PAYLOAD_W-1:0] payload;
        logic                 had_payload;
        logic                 alive;
    } item_t;

    // Result fields other than the claimed payload, which comes from the RAM
    typedef struct packed {
        status_t           status;
        logic              has_payload;
        logic              dropped;
        logic              terminate;
        logic [MASK_W-1:0] mask;
    } result_t;

endpackage

>>> hw/rtl/spqt_ram.sv
`timescale 1ns / 1ps

module spqt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, register read data on re; hold otherwise
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/spqt_engine.sv
`timescale 1ns / 1ps

module spqt_engine #(
    parameter int NUM_SIGNALS = spqt_pkg::NUM_SIGNALS_DEF,
    parameter int QUEUE_LIMIT = spqt_pkg::QUEUE_LIMIT_DEF,
    parameter int RING_DEPTH  = spqt_pkg::RING_DEPTH_DEF,
    parameter int KILL_SIGNAL = spqt_pkg::KILL_SIGNAL_DEF,
    localparam int ADDR_W = $clog2(NUM_SIGNALS * RING_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  spqt_pkg::item_t                item,
    input  logic                           exec,
    output spqt_pkg::result_t              result,
    output logic                           mem_we,
    output logic                           mem_re,
    output logic [ADDR_W-1:0]              mem_addr,
    output logic [spqt_pkg::PAYLOAD_W-1:0] mem_wdata
);

    localparam int SIG_W = $clog2(NUM_SIGNALS);
    localparam int IDX_W = (SIG_W > spqt_pkg::SIGNO_W) ? SIG_W : spqt_pkg::SIGNO_W;
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int LIMIT = (QUEUE_LIMIT < RING_DEPTH) ? QUEUE_LIMIT : RING_DEPTH;

    // Per-signal state
    logic [NUM_SIGNALS-1:0] plain_reg;
    logic [NUM_SIGNALS-1:0] summary_reg;
    logic [PTR_W-1:0]       head_reg  [NUM_SIGNALS];
    logic [PTR_W-1:0]       tail_reg  [NUM_SIGNALS];
    logic [CNT_W-1:0]       count_reg [NUM_SIGNALS];

    logic [IDX_W-1:0]       signo_ext;
    logic [SIG_W-1:0]       idx;
    logic                   sig_ok;
    logic [PTR_W-1:0]       hd;
    logic [PTR_W-1:0]       tl;
    logic [CNT_W-1:0]       cnt;
    logic                   plain_next;
    logic [PTR_W-1:0]       head_next;
    logic [PTR_W-1:0]       tail_next;
    logic [CNT_W-1:0]       count_next;
    logic                   summary_next;
    logic [PTR_W-1:0]       slot;
    logic                   we;
    logic                   re;
    logic [NUM_SIGNALS-1:0] mask_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == '0)
        begin
            r = PTR_W'(RING_DEPTH - 1);
        end
        else
        begin
            r = p - 1'b1;
        end
        return r;
    endfunction

    // Select the addressed signal
    assign signo_ext = IDX_W'(item.signo);
    assign idx       = signo_ext[SIG_W-1:0];
    assign sig_ok    = (item.signo != '0) && (32'(item.signo) < NUM_SIGNALS);
    assign hd        = head_reg[idx];
    assign tl        = tail_reg[idx];
    assign cnt       = count_reg[idx];

    // Decode the command against the signal's current state
    always_comb
    begin
        plain_next         = plain_reg[idx];
        head_next          = hd;
        tail_next          = tl;
        count_next         = cnt;
        slot               = hd;
        we                 = 1'b0;
        re                 = 1'b0;
        result.status      = spqt_pkg::ST_OK;
        result.has_payload = 1'b0;
        result.dropped     = 1'b0;
        result.terminate   = 1'b0;

        if (!sig_ok)
        begin
            result.status = spqt_pkg::ST_INVALID;
        end
        else
        begin
            case (item.command)
                spqt_pkg::CMD_SEND:
                begin
                    if (item.alive)
                    begin
                        plain_next       = 1'b1;
                        result.terminate = (32'(item.signo) == KILL_SIGNAL);
                    end
                end
                spqt_pkg::CMD_QSEND:
                begin
                    if (item.alive)
                    begin
                        if (cnt >= CNT_W'(LIMIT))
                        begin
                            result.status = spqt_pkg::ST_FULL;
                        end
                        else
                        begin
                            slot             = tl;
                            we               = 1'b1;
                            tail_next        = ptr_inc(tl);
                            count_next       = cnt + 1'b1;
                            result.terminate = (32'(item.signo) == KILL_SIGNAL);
                        end
                    end
                end
                spqt_pkg::CMD_CLAIM:
                begin
                    if (!summary_reg[idx])
                    begin
                        result.status = spqt_pkg::ST_EMPTY;
                    end
                    else if (cnt != '0)
                    begin
                        // Oldest payload goes first
                        slot               = hd;
                        re                 = 1'b1;
                        result.has_payload = 1'b1;
                        head_next          = ptr_inc(hd);
                        count_next         = cnt - 1'b1;
                    end
                    else
                    begin
                        plain_next = 1'b0;
                    end
                end
                spqt_pkg::CMD_RESTORE:
                begin
                    if (item.had_payload)
                    begin
                        if (cnt >= CNT_W'(RING_DEPTH))
                        begin
                            plain_next     = 1'b1;
                            result.dropped = 1'b1;
                        end
                        else
                        begin
                            // Push back in front of the head
                            head_next  = ptr_dec(hd);
                            slot       = ptr_dec(hd);
                            we         = 1'b1;
                            count_next = cnt + 1'b1;
                        end
                    end
                    else
                    begin
                        plain_next = 1'b1;
                    end
                end
                default:
                begin
                    result.status = spqt_pkg::ST_OK;
                end
            endcase
        end

        summary_next = plain_next | (count_next != '0);
        mask_next    = summary_reg;
        if (sig_ok)
        begin
            mask_next[idx] = summary_next;
        end
        result.mask = spqt_pkg::MASK_W'(mask_next);
    end

    // Drive the payload RAM
    assign mem_we    = exec && we;
    assign mem_re    = exec && re;
    assign mem_addr  = ADDR_W'(32'(idx) * RING_DEPTH + 32'(slot));
    assign mem_wdata = item.payload;

    // Commit the signal's state on each executed beat that names a valid signal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_reg   <= '0;
            summary_reg <= '0;
            for (int i = 0; i < NUM_SIGNALS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (exec && sig_ok)
        begin
            plain_reg[idx]   <= plain_next;
            summary_reg[idx] <= summary_next;
            head_reg[idx]    <= head_next;
            tail_reg[idx]    <= tail_next;
            count_reg[idx]   <= count_next;
        end
    end

endmodule

>>> hw/rtl/signal_pending_queue_table.sv
`timescale 1ns / 1ps
// A result beat is registered from its command beat, held in the input register
// until the result register can take it. Throughput: one command per cycle while
// result beats are taken; each command's pointer update and payload RAM access,
// if any, happen in the same read-modify-write cycle. Reset clears all pending bits,
// ring pointers and counts at once, not the payload RAM; no warm-up follows reset.

module signal_pending_queue_table #(
    parameter int NUM_SIGNALS = spqt_pkg::NUM_SIGNALS_DEF,
    parameter int QUEUE_LIMIT = spqt_pkg::QUEUE_LIMIT_DEF,
    parameter int RING_DEPTH  = spqt_pkg::RING_DEPTH_DEF,
    parameter int KILL_SIGNAL = spqt_pkg::KILL_SIGNAL_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [spqt_pkg::SIGNO_W-1:0]   signo,
    input  logic [spqt_pkg::PAYLOAD_W-1:0] payload,
    input  logic                           restore_had_payload,
    input  logic                           target_alive,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [spqt_pkg::PAYLOAD_W-1:0] claimed_payload,
    output logic                           claimed_has_payload,
    output logic                           restore_dropped,
    output logic                           terminate_request,
    output logic [spqt_pkg::MASK_W-1:0]    pending_mask
);

    localparam int ADDR_W = $clog2(NUM_SIGNALS * RING_DEPTH);

    logic                           item_valid_reg;
    spqt_pkg::item_t                item_reg;
    logic                           out_valid_reg;
    spqt_pkg::result_t              res_reg;
    spqt_pkg::result_t              res_next;
    logic                           exec;
    logic                           mem_we;
    logic                           mem_re;
    logic [ADDR_W-1:0]              mem_addr;
    logic [spqt_pkg::PAYLOAD_W-1:0] mem_wdata;
    logic [spqt_pkg::PAYLOAD_W-1:0] mem_rdata;

    // Advance the held command whenever the result register can take it
    assign exec     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || exec;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command     <= spqt_pkg::cmd_t'(command);
            item_reg.signo       <= signo;
            item_reg.payload     <= payload;
            item_reg.had_payload <= restore_had_payload;
            item_reg.alive       <= target_alive;
        end
    end

    spqt_engine #(
        .NUM_SIGNALS (NUM_SIGNALS),
        .QUEUE_LIMIT (QUEUE_LIMIT),
        .RING_DEPTH  (RING_DEPTH),
        .KILL_SIGNAL (KILL_SIGNAL)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_reg),
        .exec      (exec),
        .result    (res_next),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata)
    );

    // Payload rings of all signals, read only when a result beat is loaded
    spqt_ram #(
        .WIDTH (spqt_pkg::PAYLOAD_W),
        .DEPTH (NUM_SIGNALS * RING_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result beat
    assign out_valid           = out_valid_reg;
    assign status              = res_reg.status;
    assign claimed_payload     = res_reg.has_payload ? mem_rdata : '0;
    assign claimed_has_payload = res_reg.has_payload;
    assign restore_dropped     = res_reg.dropped;
    assign terminate_request   = res_reg.terminate;
    assign pending_mask        = res_reg.mask;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RING_W = $clog2(spqt_pkg::RING_DEPTH_DEF);
    localparam int QUEUE_CAP =
        (spqt_pkg::QUEUE_LIMIT_DEF < spqt_pkg::RING_DEPTH_DEF) ? spqt_pkg::QUEUE_LIMIT_DEF
                                                               : spqt_pkg::RING_DEPTH_DEF;
    localparam int RANDOM_BEATS = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [spqt_pkg::PAYLOAD_W-1:0] ONES = '1;
    localparam logic [spqt_pkg::MASK_W-1:0] M_KILL =
        spqt_pkg::MASK_W'(1) << spqt_pkg::KILL_SIGNAL_DEF;
    localparam logic [spqt_pkg::MASK_W-1:0] M_TOP = spqt_pkg::MASK_W'(1) << 31;
    localparam logic [spqt_pkg::MASK_W-1:0] M_ONE = spqt_pkg::MASK_W'(1) << 1;

    // What one result beat carries
    typedef struct packed {
        spqt_pkg::status_t              status;
        logic [spqt_pkg::PAYLOAD_W-1:0] payload;
        logic                           has_payload;
        logic                           dropped;
        logic                           terminate;
        logic [spqt_pkg::MASK_W-1:0]    mask;
    } outcome_t;

    // Directed row: command fields, then a hand-written outcome where fixed is set
    typedef struct {
        spqt_pkg::cmd_t                 cmd;
        logic [spqt_pkg::SIGNO_W-1:0]   sig;
        logic [spqt_pkg::PAYLOAD_W-1:0] pay;
        bit                             had;
        bit                             alive;
        bit                             fixed;
        spqt_pkg::status_t              st;
        bit                             term;
        bit                             drop;
        logic [spqt_pkg::MASK_W-1:0]    mask;
    } dir_row_t;

    localparam int DIR_ROWS = 27;
    dir_row_t dir_tbl [DIR_ROWS] = '{
        '{spqt_pkg::CMD_CLAIM,   5'd5,  64'd0, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_EMPTY, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_SEND,    5'd0,  64'd0, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_INVALID, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_QSEND,   5'd0,  ONES,  1'b1, 1'b1, 1'b1,
          spqt_pkg::ST_INVALID, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd0,  64'd0, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_INVALID, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_RESTORE, 5'd0,  ONES,  1'b1, 1'b0, 1'b1,
          spqt_pkg::ST_INVALID, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_SEND,    5'd9,  64'd0, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_OK, 1'b1, 1'b0, M_KILL},
        '{spqt_pkg::CMD_SEND,    5'd31, 64'd0, 1'b0, 1'b0, 1'b1,
          spqt_pkg::ST_OK, 1'b0, 1'b0, M_KILL},
        '{spqt_pkg::CMD_QSEND,   5'd31, ONES,  1'b0, 1'b0, 1'b1,
          spqt_pkg::ST_OK, 1'b0, 1'b0, M_KILL},
        '{spqt_pkg::CMD_QSEND,   5'd31, ONES,  1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_OK, 1'b0, 1'b0, M_KILL | M_TOP},
        '{spqt_pkg::CMD_QSEND,   5'd31, 64'd0, 1'b1, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_QSEND,   5'd31, 64'h8000_0000_0000_0001, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_QSEND,   5'd31, 64'h1234, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_FULL, 1'b0, 1'b0, M_KILL | M_TOP},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b0, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_RESTORE, 5'd31, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_RESTORE, 5'd31, 64'h5555_5555_5555_5555, 1'b1, 1'b0, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_RESTORE, 5'd31, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_QSEND,   5'd9,  64'h9, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_RESTORE, 5'd1,  ONES,  1'b0, 1'b0, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd31, 64'd0, 1'b0, 1'b1, 1'b1,
          spqt_pkg::ST_EMPTY, 1'b0, 1'b0, M_KILL | M_ONE},
        '{spqt_pkg::CMD_CLAIM,   5'd9,  64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd9,  64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0},
        '{spqt_pkg::CMD_CLAIM,   5'd1,  64'd0, 1'b0, 1'b1, 1'b0,
          spqt_pkg::ST_OK, 1'b0, 1'b0, '0}
    };

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [1:0]                     command = spqt_pkg::CMD_SEND;
    logic [spqt_pkg::SIGNO_W-1:0]   signo = '0;
    logic [spqt_pkg::PAYLOAD_W-1:0] payload = '0;
    logic                           restore_had_payload = 1'b0;
    logic                           target_alive = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [1:0]                     status;
    logic [spqt_pkg::PAYLOAD_W-1:0] claimed_payload;
    logic                           claimed_has_payload;
    logic                           restore_dropped;
    logic                           terminate_request;
    logic [spqt_pkg::MASK_W-1:0]    pending_mask;

    // Side band held with each command beat: hand-written outcome, if any
    bit                             beat_fixed = 1'b0;
    outcome_t                       beat_want = '0;

    // Shadow of the table state
    logic [spqt_pkg::PAYLOAD_W-1:0] ring_mem [spqt_pkg::NUM_SIGNALS_DEF][spqt_pkg::RING_DEPTH_DEF];
    logic [RING_W-1:0]              ring_rd [spqt_pkg::NUM_SIGNALS_DEF];
    logic [RING_W-1:0]              ring_wr [spqt_pkg::NUM_SIGNALS_DEF];
    logic [RING_W:0]                ring_fill [spqt_pkg::NUM_SIGNALS_DEF];
    logic [spqt_pkg::MASK_W-1:0]    plain_bits = '0;
    logic [spqt_pkg::MASK_W-1:0]    summary_bits = '0;

    outcome_t outcome_q [$];
    int       errs = 0;
    int       cycles = 0;
    int       tx_idle = 0;
    int       rx_idle = 0;
    int       phase = 0;
    bit       rx_hold = 1'b0;

    signal_pending_queue_table i_dut (.*);

    always #5 clk = ~clk;

    // Apply one command to the shadow table and return the outcome it produces
    function automatic outcome_t apply_signal_cmd(input spqt_pkg::item_t b);
        outcome_t                    o;
        int                          s;
        logic [spqt_pkg::MASK_W-1:0] m;
        o = '0;
        o.status = spqt_pkg::ST_OK;
        s = int'(b.signo);
        m = spqt_pkg::MASK_W'(1) << s;
        if (s == 0 || s >= spqt_pkg::NUM_SIGNALS_DEF)
        begin
            o.status = spqt_pkg::ST_INVALID;
        end
        else
        begin
            case (b.command)
                spqt_pkg::CMD_SEND:
                begin
                    if (b.alive)
                    begin
                        plain_bits |= m;
                        o.terminate = (s == spqt_pkg::KILL_SIGNAL_DEF);
                    end
                end
                spqt_pkg::CMD_QSEND:
                begin
                    if (b.alive)
                    begin
                        if (int'(ring_fill[s]) >= QUEUE_CAP)
                        begin
                            o.status = spqt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ring_mem[s][ring_wr[s]] = b.payload;
                            ring_wr[s] = ring_wr[s] + 1'b1;
                            ring_fill[s] = ring_fill[s] + 1'b1;
                            o.terminate = (s == spqt_pkg::KILL_SIGNAL_DEF);
                        end
                    end
                end
                spqt_pkg::CMD_CLAIM:
                begin
                    if ((summary_bits & m) == '0)
                    begin
                        o.status = spqt_pkg::ST_EMPTY;
                    end
                    else if (ring_fill[s] != '0)
                    begin
                        o.payload = ring_mem[s][ring_rd[s]];
                        o.has_payload = 1'b1;
                        ring_rd[s] = ring_rd[s] + 1'b1;
                        ring_fill[s] = ring_fill[s] - 1'b1;
                    end
                    else
                    begin
                        plain_bits &= ~m;
                    end
                end
                default:
                begin
                    // Push back at the head; a full ring or a restore without payload falls back to the plain bit
                    if (b.had_payload && int'(ring_fill[s]) < spqt_pkg::RING_DEPTH_DEF)
                    begin
                        ring_rd[s] = ring_rd[s] - 1'b1;
                        ring_mem[s][ring_rd[s]] = b.payload;
                        ring_fill[s] = ring_fill[s] + 1'b1;
                    end
                    else
                    begin
                        plain_bits |= m;
                        o.dropped = b.had_payload;
                    end
                end
            endcase
            if ((plain_bits & m) != '0 || ring_fill[s] != '0)
                summary_bits |= m;
            else
                summary_bits &= ~m;
        end
        o.mask = summary_bits;
        return o;
    endfunction

    // Draw a random command, mostly on a few busy signals so rings fill and drain
    function automatic spqt_pkg::item_t random_beat();
        spqt_pkg::item_t b;
        int              r;
        int              hot [4];
        hot = '{9, 31, 3, 17};
        r = $urandom_range(99);
        if (r < 12)
            b.command = spqt_pkg::CMD_SEND;
        else if (r < 45)
            b.command = spqt_pkg::CMD_QSEND;
        else if (r < 80)
            b.command = spqt_pkg::CMD_CLAIM;
        else
            b.command = spqt_pkg::CMD_RESTORE;
        r = $urandom_range(99);
        if (r < 3)
            b.signo = '0;
        else if (r < 65)
            b.signo = spqt_pkg::SIGNO_W'(hot[$urandom_range(3)]);
        else
            b.signo = spqt_pkg::SIGNO_W'($urandom_range(31));
        b.payload = {$urandom, $urandom};
        b.had_payload = ($urandom_range(99) < 80);
        b.alive = ($urandom_range(99) < 88);
        return b;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errs++;
        end
    endtask

    // Offer one command beat and hold it until the block takes it
    task automatic drive_beat(input spqt_pkg::item_t b, input bit fixed,
                              input outcome_t want);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= b.command;
        signo <= b.signo;
        payload <= b.payload;
        restore_had_payload <= b.had_payload;
        target_alive <= b.alive;
        beat_fixed <= fixed;
        beat_want <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Predict on accepted command beats, check accepted result beats
    always @(posedge clk)
    begin
        outcome_t        got;
        outcome_t        want;
        outcome_t        pred;
        spqt_pkg::item_t b;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{spqt_pkg::status_t'(status), claimed_payload, claimed_has_payload,
                        restore_dropped, terminate_request, pending_mask};
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    errs++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("claimed_payload", want.payload, got.payload);
                    check_field("claimed_has_payload", 64'(want.has_payload),
                                64'(got.has_payload));
                    check_field("restore_dropped", 64'(want.dropped), 64'(got.dropped));
                    check_field("terminate_request", 64'(want.terminate),
                                64'(got.terminate));
                    check_field("pending_mask", 64'(want.mask), 64'(got.mask));
                end
            end
            if (in_valid && in_ready)
            begin
                b = '{spqt_pkg::cmd_t'(command), signo, payload, restore_had_payload,
                      target_alive};
                pred = apply_signal_cmd(b);
                outcome_q.push_back(beat_fixed ? beat_want : pred);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off while the hold is on
    always @(negedge clk)
        out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle);

    // Hold off results for a long stretch so the block backs up into its input
    initial
    begin
        wait (phase == 3);
        repeat (40) @(negedge clk);
        rx_hold <= 1'b1;
        repeat (150) @(negedge clk);
        rx_hold <= 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        spqt_pkg::item_t b;
        outcome_t        w;
        for (int s = 0; s < spqt_pkg::NUM_SIGNALS_DEF; s++)
        begin
            ring_rd[s] = '0;
            ring_wr[s] = '0;
            ring_fill[s] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        phase = 1;
        tx_idle = 7;
        rx_idle = 78;
        foreach (dir_tbl[i])
        begin
            b = '{dir_tbl[i].cmd, dir_tbl[i].sig, dir_tbl[i].pay,
                  dir_tbl[i].had, dir_tbl[i].alive};
            w = '{dir_tbl[i].st, 64'd0, 1'b0, dir_tbl[i].drop, dir_tbl[i].term,
                  dir_tbl[i].mask};
            drive_beat(b, dir_tbl[i].fixed, w);
        end

        // Random beats in three idling phases
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 3)
            begin
                phase = 2;
                tx_idle = 78;
                rx_idle = 7;
            end
            else if (n == 2 * RANDOM_BEATS / 3)
            begin
                phase = 3;
                tx_idle = 0;
                rx_idle = 0;
            end
            drive_beat(random_beat(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain the outcome queue, then keep watching for stray beats before reporting
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errs == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/spqt_pkg.sv
hw/rtl/spqt_ram.sv
hw/rtl/spqt_engine.sv
hw/rtl/signal_pending_queue_table.sv
verif/tb.sv
